@@ rtl/isoep_pkg.sv @@
// isoep_pkg: shared types and sizes for the ISO 8601 timestamp to epoch parser.
// Used by isoep_front, isoep_queue, isoep_back and the top level.
// No dependencies.
package isoep_pkg;

  localparam int YEAR_W          = 14;
  localparam int FIELD_W         = 7;
  localparam int EPOCH_W         = 39;
  localparam int DEF_QUEUE_DEPTH = 2;

  // One parsed string, handed from the character parser to the arithmetic back end.
  typedef struct packed {
    logic               good;
    logic [YEAR_W-1:0]  year;
    logic [FIELD_W-1:0] month;
    logic [FIELD_W-1:0] day;
    logic [FIELD_W-1:0] hour;
    logic [FIELD_W-1:0] minute;
    logic [FIELD_W-1:0] second;
    logic               off_neg;
    logic [FIELD_W-1:0] off_hours;
    logic [FIELD_W-1:0] off_minutes;
  } isoep_rec_t;

  typedef struct packed {
    logic       valid;
    isoep_rec_t rec;
  } isoep_push_t;

endpackage

@@ rtl/iso8601_to_epoch_parser_unit.sv @@
// ISO 8601 timestamp to UTC epoch: one ASCII character per beat, result on terminator.
// Throughput: one character per cycle while the record queue is not full; the arithmetic
// back end pops one string at a time and runs its seven-step days-from-civil sequencer.
// The result beat is registered at the end of the final step, which waits while it is stalled.
// The record queue (QUEUE_DEPTH entries) stalls input only when it is full.
// Reset (rst, synchronous): parser back to the start of a string, queue empty, no result.
module iso8601_to_epoch_parser_unit #(
  parameter int QUEUE_DEPTH = isoep_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 char_valid,
  output logic                                 char_stall,
  input  logic [7:0]                           ch,
  input  logic                                 is_end,
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output logic signed [isoep_pkg::EPOCH_W-1:0] epoch_seconds,
  output logic                                 valid_res
);

  isoep_pkg::isoep_push_t push;
  isoep_pkg::isoep_rec_t  head;
  logic                   queue_full;
  logic                   queue_nonempty;
  logic                   pop;

  isoep_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .ch         (ch),
    .is_end     (is_end),
    .queue_full (queue_full),
    .push       (push)
  );

  isoep_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (queue_full),
    .nonempty (queue_nonempty),
    .head     (head),
    .pop      (pop)
  );

  isoep_back u_back (
    .clk           (clk),
    .rst           (rst),
    .rec_valid     (queue_nonempty),
    .rec           (head),
    .pop           (pop),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .epoch_seconds (epoch_seconds),
    .valid_res     (valid_res)
  );

endmodule

@@ rtl/isoep_front.sv @@
// isoep_front: character-by-character parser of YYYY-MM-DDTHH:MM:SS[.f][Z|+-HH:MM].
// Pushes one parsed record into the queue per terminator beat.
// Depends on isoep_pkg.
module isoep_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_stall,
  input  logic [7:0]          ch,
  input  logic                is_end,
  input  logic                queue_full,
  output isoep_pkg::isoep_push_t push
);

  typedef enum logic [2:0] {
    PH_MAIN,
    PH_AFTER_SEC,
    PH_FRAC,
    PH_OFF_H,
    PH_OFF_M,
    PH_DONE
  } phase_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [4:0] POS_LAST = 5'd18;
  localparam logic [4:0] POS_END  = 5'd19;

  function automatic logic [isoep_pkg::FIELD_W-1:0] mac7(
    input logic [isoep_pkg::FIELD_W-1:0] a,
    input logic [3:0] d
  );
    logic [isoep_pkg::FIELD_W+2:0] t;
    t = {a, 3'b000} + {2'b00, a, 1'b0} + (isoep_pkg::FIELD_W+3)'(d);
    return t[isoep_pkg::FIELD_W-1:0];
  endfunction

  phase_t                        phase, phase_next;
  logic [4:0]                    char_position, char_position_next;
  logic [isoep_pkg::YEAR_W-1:0]  year_acc, year_acc_next;
  logic [isoep_pkg::FIELD_W-1:0] month_acc, month_acc_next;
  logic [isoep_pkg::FIELD_W-1:0] day_acc, day_acc_next;
  logic [isoep_pkg::FIELD_W-1:0] hour_acc, hour_acc_next;
  logic [isoep_pkg::FIELD_W-1:0] minute_acc, minute_acc_next;
  logic [isoep_pkg::FIELD_W-1:0] second_acc, second_acc_next;
  logic                          offset_negative, offset_negative_next;
  logic [isoep_pkg::FIELD_W-1:0] offset_hours, offset_hours_next;
  logic [isoep_pkg::FIELD_W-1:0] offset_minutes, offset_minutes_next;
  logic [1:0]                    offset_digit_count, offset_digit_count_next;
  logic                          format_error, format_error_next;

  logic       accept;
  logic       digit;
  logic [3:0] dval;
  logic       main_ok;
  logic       sign_char;

  assign char_stall = queue_full;
  assign accept     = char_valid && !queue_full;
  assign digit      = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign dval       = ch[3:0];
  assign sign_char  = (ch == CH_PLUS) || (ch == CH_DASH);

  always_comb begin
    push.valid           = accept && is_end;
    push.rec.good        = !format_error && (phase != PH_MAIN);
    push.rec.year        = year_acc;
    push.rec.month       = month_acc;
    push.rec.day         = day_acc;
    push.rec.hour        = hour_acc;
    push.rec.minute      = minute_acc;
    push.rec.second      = second_acc;
    push.rec.off_neg     = offset_negative;
    push.rec.off_hours   = offset_hours;
    push.rec.off_minutes = offset_minutes;
  end

  always_comb begin
    phase_next              = phase;
    char_position_next      = char_position;
    year_acc_next           = year_acc;
    month_acc_next          = month_acc;
    day_acc_next            = day_acc;
    hour_acc_next           = hour_acc;
    minute_acc_next         = minute_acc;
    second_acc_next         = second_acc;
    offset_negative_next    = offset_negative;
    offset_hours_next       = offset_hours;
    offset_minutes_next     = offset_minutes;
    offset_digit_count_next = offset_digit_count;
    format_error_next       = format_error;
    main_ok                 = 1'b0;

    if (accept && is_end) begin
      phase_next              = PH_MAIN;
      char_position_next      = '0;
      year_acc_next           = '0;
      month_acc_next          = '0;
      day_acc_next            = '0;
      hour_acc_next           = '0;
      minute_acc_next         = '0;
      second_acc_next         = '0;
      offset_negative_next    = 1'b0;
      offset_hours_next       = '0;
      offset_minutes_next     = '0;
      offset_digit_count_next = '0;
      format_error_next       = 1'b0;
    end else if (accept && !format_error) begin
      case (phase)
        PH_MAIN: begin
          if (char_position == 5'd4 || char_position == 5'd7) begin
            main_ok = (ch == CH_DASH);
          end else if (char_position == 5'd10) begin
            main_ok = (ch == CH_T);
          end else if (char_position == 5'd13 || char_position == 5'd16) begin
            main_ok = (ch == CH_COLON);
          end else begin
            main_ok = digit;
            if (digit) begin
              if (char_position <= 5'd3) begin
                year_acc_next = isoep_pkg::YEAR_W'({year_acc, 3'b000}
                                + {2'b00, year_acc, 1'b0}
                                + (isoep_pkg::YEAR_W+3)'(dval));
              end else if (char_position <= 5'd6) begin
                month_acc_next = mac7(month_acc, dval);
              end else if (char_position <= 5'd9) begin
                day_acc_next = mac7(day_acc, dval);
              end else if (char_position <= 5'd12) begin
                hour_acc_next = mac7(hour_acc, dval);
              end else if (char_position <= 5'd15) begin
                minute_acc_next = mac7(minute_acc, dval);
              end else begin
                second_acc_next = mac7(second_acc, dval);
              end
            end
          end
          if (!main_ok) begin
            format_error_next = 1'b1;
          end else if (char_position >= POS_LAST) begin
            char_position_next = POS_END;
            phase_next         = PH_AFTER_SEC;
          end else begin
            char_position_next = char_position + 5'd1;
          end
        end
        PH_AFTER_SEC, PH_FRAC: begin
          if (ch == CH_Z) begin
            phase_next = PH_DONE;
          end else if (sign_char) begin
            offset_negative_next    = (ch == CH_DASH);
            offset_hours_next       = '0;
            offset_minutes_next     = '0;
            offset_digit_count_next = '0;
            phase_next              = PH_OFF_H;
          end else if (phase == PH_AFTER_SEC) begin
            if (ch == CH_DOT) begin
              phase_next = PH_FRAC;
            end else begin
              format_error_next = 1'b1;
            end
          end
        end
        PH_OFF_H: begin
          if (digit && offset_digit_count < 2'd2) begin
            offset_hours_next       = mac7(offset_hours, dval);
            offset_digit_count_next = offset_digit_count + 2'd1;
          end else if (ch == CH_COLON && offset_digit_count != 2'd0) begin
            offset_digit_count_next = '0;
            phase_next              = PH_OFF_M;
          end else begin
            phase_next = PH_DONE;
          end
        end
        PH_OFF_M: begin
          if (digit && offset_digit_count < 2'd2) begin
            offset_minutes_next     = mac7(offset_minutes, dval);
            offset_digit_count_next = offset_digit_count + 2'd1;
          end else begin
            phase_next = PH_DONE;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_MAIN;
      char_position      <= '0;
      year_acc           <= '0;
      month_acc          <= '0;
      day_acc            <= '0;
      hour_acc           <= '0;
      minute_acc         <= '0;
      second_acc         <= '0;
      offset_negative    <= 1'b0;
      offset_hours       <= '0;
      offset_minutes     <= '0;
      offset_digit_count <= '0;
      format_error       <= 1'b0;
    end else begin
      phase              <= phase_next;
      char_position      <= char_position_next;
      year_acc           <= year_acc_next;
      month_acc          <= month_acc_next;
      day_acc            <= day_acc_next;
      hour_acc           <= hour_acc_next;
      minute_acc         <= minute_acc_next;
      second_acc         <= second_acc_next;
      offset_negative    <= offset_negative_next;
      offset_hours       <= offset_hours_next;
      offset_minutes     <= offset_minutes_next;
      offset_digit_count <= offset_digit_count_next;
      format_error       <= format_error_next;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    char_position <= POS_END)
    else $error("char position past end of main fields");

  a_suffix_after_fields: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_MAIN) |-> (char_position == POS_END))
    else $error("suffix phase entered before all main fields");

endmodule

@@ rtl/isoep_queue.sv @@
// isoep_queue: short record queue between the parser front and the arithmetic back end.
// Depends on isoep_pkg.
module isoep_queue #(
  parameter int DEPTH = isoep_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  isoep_pkg::isoep_push_t   push,
  output logic                     full,
  output logic                     nonempty,
  output isoep_pkg::isoep_rec_t    head,
  input  logic                     pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  isoep_pkg::isoep_rec_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_FULL);
  assign nonempty = (count != '0);
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push.valid, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !full)
    else $error("record pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty)
    else $error("record popped from empty queue");

endmodule

@@ rtl/isoep_back.sv @@
// isoep_back: days-from-civil arithmetic sequencer, one record at a time,
// with a registered result beat. Depends on isoep_pkg.
module isoep_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               rec_valid,
  input  isoep_pkg::isoep_rec_t              rec,
  output logic                               pop,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic signed [isoep_pkg::EPOCH_W-1:0] epoch_seconds,
  output logic                               valid_res
);

  localparam int FW = isoep_pkg::FIELD_W;
  localparam int YW = isoep_pkg::YEAR_W;

  localparam logic [10:0] ERA_RECIP  = 11'd1311;   // 2^15/25, applied to year/16
  localparam logic [13:0] FIFTH      = 14'd13108;  // 2^16/5
  localparam logic [7:0]  MP_MULT    = 8'd153;
  localparam logic [13:0] ERA_YEARS  = 14'd400;
  localparam logic [8:0]  LAST_YOE   = 9'd399;
  localparam logic signed [23:0] DAYS_PER_ERA = 24'sd146097;
  localparam logic signed [23:0] EPOCH_SHIFT  = 24'sd719468;
  localparam logic signed [40:0] SECS_PER_DAY = 41'sd86400;
  localparam logic [18:0] SECS_PER_HOUR = 19'd3600;
  localparam logic [18:0] SECS_PER_MIN  = 19'd60;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ERA,
    ST_YOE,
    ST_DOE,
    ST_DAYS,
    ST_SECS,
    ST_SUM
  } state_t;

  state_t state;

  // operand and partial-result registers
  logic                good;
  logic                yneg;
  logic [YW-1:0]       y;
  logic [FW-1:0]       mp;
  logic [FW-1:0]       day;
  logic [FW-1:0]       hour;
  logic [FW-1:0]       minute;
  logic [FW-1:0]       second;
  logic                off_neg;
  logic [FW-1:0]       off_hours;
  logic [FW-1:0]       off_minutes;
  logic [20:0]         q_prod;
  logic [14:0]         doy_num;
  logic [18:0]         tod;
  logic signed [19:0]  soff;
  logic signed [6:0]   era;
  logic [28:0]         doy_prod;
  logic [8:0]          yoe;
  logic signed [12:0]  doy;
  logic signed [18:0]  doe;
  logic signed [23:0]  days;
  logic signed [40:0]  day_secs;

  logic                dec;
  logic [YW-1:0]       y_c;
  logic [FW-1:0]       mp_c;
  logic [20:0]         q_prod_c;
  logic [14:0]         doy_num_c;
  logic [18:0]         tod_c;
  logic [18:0]         off_c;
  logic signed [19:0]  soff_c;
  logic signed [6:0]   era_c;
  logic [28:0]         doy_prod_c;
  logic [8:0]          yoe_c;
  logic signed [12:0]  doy_c;
  logic [1:0]          cent_c;
  logic signed [18:0]  doe_c;
  logic signed [23:0]  days_c;
  logic signed [40:0]  day_secs_c;
  logic signed [40:0]  sum_c;
  logic                out_free;

  assign pop      = (state == ST_IDLE) && rec_valid;
  assign out_free = !res_valid || !res_stall;

  always_comb begin
    dec        = (rec.month <= FW'(2));
    y_c        = rec.year - YW'(dec);
    mp_c       = dec ? rec.month + FW'(9) : rec.month - FW'(3);

    q_prod_c   = 21'(y[YW-1:4]) * 21'(ERA_RECIP);
    doy_num_c  = 15'(mp) * 15'(MP_MULT) + 15'd2;
    tod_c      = 19'(hour) * SECS_PER_HOUR + 19'(minute) * SECS_PER_MIN + 19'(second);
    off_c      = 19'(off_hours) * SECS_PER_HOUR + 19'(off_minutes) * SECS_PER_MIN;
    soff_c     = off_neg ? -$signed({1'b0, off_c}) : $signed({1'b0, off_c});

    era_c      = yneg ? -7'sd1 : $signed({1'b0, q_prod[20:15]});
    doy_prod_c = 29'(doy_num) * 29'(FIFTH);

    yoe_c      = yneg ? LAST_YOE : 9'(y - 14'(14'(era[5:0]) * ERA_YEARS));
    doy_c      = $signed({1'b0, doy_prod[27:16]}) + $signed({6'b000000, day}) - 13'sd1;

    cent_c     = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
    doe_c      = $signed(19'(yoe) * 19'd365) + $signed(19'(yoe[8:2]))
                 - $signed(19'(cent_c)) + 19'(doy);

    days_c     = 24'(era) * DAYS_PER_ERA + 24'(doe) - EPOCH_SHIFT;
    day_secs_c = 41'(days) * SECS_PER_DAY;
    sum_c      = day_secs + $signed({22'd0, tod}) - 41'(soff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (state == ST_SUM && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (rec_valid) begin
            good        <= rec.good;
            yneg        <= dec && (rec.year == '0);
            y           <= y_c;
            mp          <= mp_c;
            day         <= rec.day;
            hour        <= rec.hour;
            minute      <= rec.minute;
            second      <= rec.second;
            off_neg     <= rec.off_neg;
            off_hours   <= rec.off_hours;
            off_minutes <= rec.off_minutes;
            state       <= ST_DIV;
          end
        end
        ST_DIV: begin
          q_prod  <= q_prod_c;
          doy_num <= doy_num_c;
          tod     <= tod_c;
          soff    <= soff_c;
          state   <= ST_ERA;
        end
        ST_ERA: begin
          era      <= era_c;
          doy_prod <= doy_prod_c;
          state    <= ST_YOE;
        end
        ST_YOE: begin
          yoe   <= yoe_c;
          doy   <= doy_c;
          state <= ST_DOE;
        end
        ST_DOE: begin
          doe   <= doe_c;
          state <= ST_DAYS;
        end
        ST_DAYS: begin
          days  <= days_c;
          state <= ST_SECS;
        end
        ST_SECS: begin
          day_secs <= day_secs_c;
          state    <= ST_SUM;
        end
        ST_SUM: begin
          if (out_free) begin
            valid_res     <= good;
            epoch_seconds <= good ? sum_c[isoep_pkg::EPOCH_W-1:0] : '0;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_fail_is_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !valid_res) |-> (epoch_seconds == '0))
    else $error("failed parse delivered a nonzero epoch");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM && res_valid && res_stall) |=> (state == ST_SUM))
    else $error("sequencer left final step while result beat was stalled");

endmodule
